[rtl/core/ppd_pkg.sv]
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and fixed widths of the position PID drive: sequencer states,
// multiplier operand selects, the control word and the register map.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_WIN  = 3'd4;

  localparam logic signed [CFG_W-1:0] GAIN_PROP_RST  = 16'sd256;
  localparam logic signed [CFG_W-1:0] GAIN_INTEG_RST = 16'sd0;
  localparam logic signed [CFG_W-1:0] GAIN_DERIV_RST = 16'sd0;
  localparam logic [CFG_W-1:0]        DEADBAND_RST   = 16'd2;
  localparam logic [CFG_W-1:0]        INTEG_WIN_RST  = 16'd10;

  // error and integral
  localparam int ERR_W = 25;
  localparam int SUM_W = 20;
  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // shared multiplier
  localparam int MA_W = 19;
  localparam int MB_W = 27;
  localparam int MP_W = MA_W + MB_W;

  // term accumulator and clipped power (q8.8 percent)
  localparam int ACC_W = 43;
  localparam int PW_W  = 16;
  localparam int MAG_W = PW_W - 1;
  localparam logic signed [ACC_W-1:0] I_HI = 43'sd2560;
  localparam logic signed [ACC_W-1:0] I_LO = -43'sd2560;
  localparam logic signed [ACC_W-1:0] P_HI = 43'sd25600;
  localparam logic signed [ACC_W-1:0] P_LO = -43'sd25600;

  // duty scaling: divide by 25600 as shift by 8, then by 100 via reciprocal
  localparam int Y_LSB    = 8;
  localparam int Y_W      = 18;
  localparam int Q_W      = 12;
  localparam int RECIP_SH = 22;
  localparam logic [16:0]    RECIP_100 = 17'd41943;
  localparam logic [Y_W-1:0] DIV_K     = 18'd100;

  localparam int DUTY_W  = 11;
  localparam int LEVEL_W = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_UPD,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_SUM,
    ST_CLIP,
    ST_MAG,
    ST_DV1,
    ST_DV2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MSEL_P,
    MSEL_I,
    MSEL_D,
    MSEL_MAG,
    MSEL_RECIP,
    MSEL_BACK
  } msel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_ICLIP,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    ld_err;
    logic    upd;
    logic    mul_en;
    msel_t   msel;
    acc_op_t acc_op;
    logic    ld_pw;
    logic    ld_y;
    logic    ld_q0;
    logic    ld_out;
  } ctrl_t;

endpackage

[rtl/core/ppd_if.sv]
// ----------------------------------------------------------------------------
// ppd channel interfaces
// Valid/ready channels for position samples and for drive words.
// ----------------------------------------------------------------------------
interface ppd_in_if #(
  parameter int POS_WIDTH = 24
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] target_pos;
  logic signed [POS_WIDTH-1:0] measured_pos;

  modport source (output valid, output target_pos, output measured_pos, input ready);
  modport sink (input valid, input target_pos, input measured_pos, output ready);
endinterface

interface ppd_out_if;
  logic              valid;
  logic              ready;
  logic [10:0]       duty_fwd;
  logic [10:0]       duty_rev;
  logic signed [7:0] drive_level;

  modport source (output valid, output duty_fwd, output duty_rev, output drive_level,
                  input ready);
  modport sink (input valid, input duty_fwd, input duty_rev, input drive_level,
                output ready);
endinterface

[rtl/core/ppd_mul.sv]
// ----------------------------------------------------------------------------
// ppd_mul
// Shared signed multiplier with a registered product; holds when not enabled.
// ----------------------------------------------------------------------------
module ppd_mul
  import ppd_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

[rtl/core/ppd_seq.sv]
// ----------------------------------------------------------------------------
// ppd_seq
// Sequencer of the drive update: steps the shared multiplier through the P,
// I, D and duty scaling products, one step a cycle save for handshake waits.
// ----------------------------------------------------------------------------
module ppd_seq
  import ppd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_ERR;
      ST_ERR:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_MP;
      ST_MP:   state_next = ST_MI;
      ST_MI:   state_next = ST_MD;
      ST_MD:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_CLIP;
      ST_CLIP: state_next = ST_MAG;
      ST_MAG:  state_next = ST_DV1;
      ST_DV1:  state_next = ST_DV2;
      ST_DV2:  state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.msel     = MSEL_P;
    ctrl.acc_op   = ACC_HOLD;
    case (state)
      ST_IDLE: ctrl.in_ready = 1'b1;
      ST_ERR:  ctrl.ld_err = 1'b1;
      ST_UPD:  ctrl.upd = 1'b1;
      ST_MP: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_P;
      end
      ST_MI: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_I;
        ctrl.acc_op = ACC_LOAD;
      end
      ST_MD: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_D;
        ctrl.acc_op = ACC_ADD_ICLIP;
      end
      ST_SUM:  ctrl.acc_op = ACC_ADD;
      ST_CLIP: ctrl.ld_pw = 1'b1;
      ST_MAG: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_MAG;
      end
      ST_DV1: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_RECIP;
        ctrl.ld_y   = 1'b1;
      end
      ST_DV2: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_BACK;
        ctrl.ld_q0  = 1'b1;
      end
      ST_DONE: ctrl.ld_out = out_free;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

[rtl/core/pid_position_pwm_drive.sv]
// the sequencer steps a sample through error, update, P, I, D, sum, clip,
//   magnitude and divide states, using the one shared 19x27 multiplier for
//   the P, I, D and duty scaling products; it takes a sample only when idle
// a finished word waits in the output register while the next sample is taken
// reset (rst, synchronous): gains and limits to defaults, integral and last
//   error cleared, output empty
// ----------------------------------------------------------------------------
// pid_position_pwm_drive
// Position PID controller with windowed integral, clipped terms, deadband and
// two-pin H-bridge PWM duty output.
// ----------------------------------------------------------------------------
module pid_position_pwm_drive
  import ppd_pkg::*;
#(
  parameter int POS_WIDTH = 24,
  parameter int PWM_FULL  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ppd_in_if.sink               sample,
  ppd_out_if.source            drive
);

  localparam int DW   = (POS_WIDTH + 1 > ERR_W + 1) ? POS_WIDTH + 1 : ERR_W + 1;
  localparam int HALF = PWM_FULL / 2;
  localparam int SPAN = PWM_FULL - HALF;

  ctrl_t ctrl;
  logic  in_fire;
  logic  out_free;

  // configuration registers
  logic signed [CFG_W-1:0] gain_prop;
  logic signed [CFG_W-1:0] gain_integ;
  logic signed [CFG_W-1:0] gain_deriv;
  logic [CFG_W-1:0]        deadband_ticks;
  logic [CFG_W-1:0]        integ_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop      <= GAIN_PROP_RST;
      gain_integ     <= GAIN_INTEG_RST;
      gain_deriv     <= GAIN_DERIV_RST;
      deadband_ticks <= DEADBAND_RST;
      integ_window   <= INTEG_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:  gain_prop      <= cfg_data;
        REG_GAIN_INTEG: gain_integ     <= cfg_data;
        REG_GAIN_DERIV: gain_deriv     <= cfg_data;
        REG_DEADBAND:   deadband_ticks <= cfg_data;
        REG_INTEG_WIN:  integ_window   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample.ready = ctrl.in_ready;
  assign in_fire      = sample.valid && ctrl.in_ready;
  assign out_free     = !drive.valid || drive.ready;

  ppd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // sample capture and saturated error
  logic signed [POS_WIDTH-1:0] tgt_r;
  logic signed [POS_WIDTH-1:0] meas_r;
  logic signed [DW-1:0]        diff_full;
  logic signed [ERR_W-1:0]     err_sat;
  logic signed [ERR_W-1:0]     err_r;
  logic signed [ERR_W-1:0]     last_error;
  logic signed [SUM_W-1:0]     error_sum;
  logic signed [ERR_W:0]       diff_r;
  logic [ERR_W-1:0]            aerr;
  logic signed [ERR_W:0]       sum_wide;
  logic signed [SUM_W-1:0]     sum_next;
  logic                        dz_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_r  <= sample.target_pos;
      meas_r <= sample.measured_pos;
    end
  end

  assign diff_full = DW'(tgt_r) - DW'(meas_r);

  always_comb begin
    if (diff_full > DW'(ERR_MAX)) begin
      err_sat = ERR_MAX;
    end else if (diff_full < DW'(ERR_MIN)) begin
      err_sat = ERR_MIN;
    end else begin
      err_sat = diff_full[ERR_W-1:0];
    end
  end

  assign aerr     = err_r[ERR_W-1] ? (~err_r + 1'b1) : err_r;
  assign sum_wide = (ERR_W+1)'(err_r) + (ERR_W+1)'(error_sum);

  always_comb begin
    if (aerr > ERR_W'(integ_window)) begin
      sum_next = '0;
    end else if (sum_wide > (ERR_W+1)'(SUM_MAX)) begin
      sum_next = SUM_MAX;
    end else if (sum_wide < (ERR_W+1)'(SUM_MIN)) begin
      sum_next = SUM_MIN;
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_err) begin
      err_r <= err_sat;
    end
    if (ctrl.upd) begin
      diff_r <= (ERR_W+1)'(err_r) - (ERR_W+1)'(last_error);
      dz_r   <= aerr <= ERR_W'(deadband_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (ctrl.upd) begin
      last_error <= err_r;
      error_sum  <= sum_next;
    end
  end

  // shared multiplier and its operand select
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  prod;
  logic signed [PW_W-1:0]  pw_r;
  logic [MAG_W-1:0]        mag;
  logic [Y_W-1:0]          y_r;
  logic [Q_W-1:0]          q0_r;

  assign mag = pw_r[PW_W-1] ? MAG_W'(-pw_r) : MAG_W'(pw_r);

  always_comb begin
    case (ctrl.msel)
      MSEL_P: begin
        mul_a = MA_W'(gain_prop);
        mul_b = MB_W'(err_r);
      end
      MSEL_I: begin
        mul_a = MA_W'(gain_integ);
        mul_b = MB_W'(error_sum);
      end
      MSEL_D: begin
        mul_a = MA_W'(gain_deriv);
        mul_b = MB_W'(diff_r);
      end
      MSEL_MAG: begin
        mul_a = MA_W'(SPAN);
        mul_b = MB_W'(mag);
      end
      MSEL_RECIP: begin
        mul_a = MA_W'(prod[Y_LSB+Y_W-1:Y_LSB]);
        mul_b = MB_W'(RECIP_100);
      end
      MSEL_BACK: begin
        mul_a = MA_W'(prod[RECIP_SH+Q_W-1:RECIP_SH]);
        mul_b = MB_W'(DIV_K);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ppd_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // term accumulation
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_acc;
  logic signed [ACC_W-1:0] i_term;
  logic signed [PW_W-1:0]  pw_next;

  assign prod_acc = $signed(prod[ACC_W-1:0]);

  always_comb begin
    if (prod_acc > I_HI) begin
      i_term = I_HI;
    end else if (prod_acc < I_LO) begin
      i_term = I_LO;
    end else begin
      i_term = prod_acc;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD:      acc <= prod_acc;
      ACC_ADD_ICLIP: acc <= acc + i_term;
      ACC_ADD:       acc <= acc + prod_acc;
      default:       acc <= acc;
    endcase
  end

  always_comb begin
    if (dz_r) begin
      pw_next = '0;
    end else if (acc > P_HI) begin
      pw_next = PW_W'(P_HI);
    end else if (acc < P_LO) begin
      pw_next = PW_W'(P_LO);
    end else begin
      pw_next = acc[PW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_pw) begin
      pw_r <= pw_next;
    end
    if (ctrl.ld_y) begin
      y_r <= prod[Y_LSB+Y_W-1:Y_LSB];
    end
    if (ctrl.ld_q0) begin
      q0_r <= prod[RECIP_SH+Q_W-1:RECIP_SH];
    end
  end

  // quotient fix-up: the reciprocal estimate is exact or one low
  logic [Y_W-1:0]     rem;
  logic [Q_W-1:0]     q_fix;
  logic [Q_W:0]       duty_sum;
  logic [DUTY_W-1:0]  duty;
  logic [6:0]         lvl_mag;
  logic signed [LEVEL_W-1:0] level;

  assign rem      = y_r - prod[Y_W-1:0];
  assign q_fix    = q0_r + Q_W'(rem >= DIV_K);
  assign duty_sum = (Q_W+1)'(HALF) + (Q_W+1)'(q_fix);
  assign duty     = (pw_r == '0) ? '0 : duty_sum[DUTY_W-1:0];
  assign lvl_mag  = mag[MAG_W-1:Y_LSB];
  assign level    = pw_r[PW_W-1] ? -$signed({1'b0, lvl_mag}) : $signed({1'b0, lvl_mag});

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive.valid <= 1'b0;
    end else if (ctrl.ld_out) begin
      drive.valid <= 1'b1;
    end else if (drive.ready) begin
      drive.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      drive.duty_fwd    <= (pw_r > 0) ? duty : '0;
      drive.duty_rev    <= pw_r[PW_W-1] ? duty : '0;
      drive.drive_level <= level;
    end
  end

endmodule
